// ===== rtl/core/icnc_pkg.sv =====
// Shared constants and types for the int8 codebook nearest-centroid search.
package icnc_pkg;

  localparam int CENTROIDS  = 256;
  localparam int MAX_SUBDIM = 64;

  localparam int CEN_W  = $clog2(CENTROIDS);
  localparam int POS_W  = $clog2(MAX_SUBDIM);
  localparam int LEN_W  = $clog2(MAX_SUBDIM + 1);
  localparam int ADDR_W = CEN_W + POS_W;
  localparam int CB_DEPTH = CENTROIDS * MAX_SUBDIM;

  // field widths
  localparam int CODE_W  = 8;
  localparam int SCALE_W = 16;
  localparam int Q_W     = 24;
  localparam int PROD_W  = CODE_W + SCALE_W;  // code * scale
  localparam int REC_W   = Q_W + 1;           // product + offset
  localparam int DIFF_W  = Q_W + 2;           // query - rec
  localparam int MAG_W   = DIFF_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = 57;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBDIM = 2'd2;

  // request opcodes
  localparam logic OP_CODE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd4096;
  localparam logic [Q_W-1:0]     OFFSET_RESET = 24'd0;
  localparam logic [6:0]         SUBDIM_RESET = 7'd8;

  // tags that travel with each element down the datapath
  typedef struct packed {
    logic             first;   // element 0 of a centroid
    logic             last;    // element len-1 of a centroid (len = subdim clamped to 1..64)
    logic             final_c; // last centroid of the walk
    logic [CEN_W-1:0] cen;
  } elem_tag_t;

endpackage

// ===== rtl/core/int8_codebook_nearest_centroid.sv =====
// Nearest-centroid search over an int8 codebook with one shared datapath.
// Codebook writes and non-final query requests are accepted; busy stays low.
// The final query element (position len-1, len = subdim clamped to 1..64)
// starts a walk of 256*len element steps, one per cycle; done pulses when
// the last step leaves the datapath, and busy is low from then on.
// Sync active-high reset restores scale=1.0, offset=0, subdim=8; stores are
// not cleared. done is a one-cycle strobe, the receiver cannot stall it.
module int8_codebook_nearest_centroid (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic [7:0]                     centroid,
  input  logic [5:0]                     position,
  input  logic signed [7:0]              code_value,
  input  logic signed [23:0]             query_value,
  input  logic                           cfg_we,
  input  logic [icnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [icnc_pkg::CFG_W-1:0]     cfg_data,
  output logic [7:0]                     nearest,
  output logic                           done
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic signed [icnc_pkg::SCALE_W-1:0] scale;
  logic signed [icnc_pkg::Q_W-1:0]     offset;
  logic [6:0]                          subdim;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= icnc_pkg::SCALE_RESET;
      offset <= icnc_pkg::OFFSET_RESET;
      subdim <= icnc_pkg::SUBDIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icnc_pkg::REG_SCALE:  scale  <= cfg_data[icnc_pkg::SCALE_W-1:0];
        icnc_pkg::REG_OFFSET: offset <= cfg_data[icnc_pkg::Q_W-1:0];
        icnc_pkg::REG_SUBDIM: subdim <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Elements in use, clamped to 1..MAX_SUBDIM.
  logic [icnc_pkg::LEN_W-1:0] used_len;
  always_comb begin
    if (subdim == 7'd0)
      used_len = icnc_pkg::LEN_W'(1);
    else if (32'(subdim) > icnc_pkg::MAX_SUBDIM)
      used_len = icnc_pkg::LEN_W'(icnc_pkg::MAX_SUBDIM);
    else
      used_len = icnc_pkg::LEN_W'(subdim);
  end

  logic [icnc_pkg::LEN_W-1:0] last_pos;
  assign last_pos = used_len - icnc_pkg::LEN_W'(1);

  // ---------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------
  logic accept, pos_ok, cb_we, q_we, trigger;
  assign accept  = start && !busy;
  assign pos_ok  = 32'(position) < icnc_pkg::MAX_SUBDIM;
  assign cb_we   = accept && pos_ok && (opcode == icnc_pkg::OP_CODE)
                   && (32'(centroid) < icnc_pkg::CENTROIDS);
  assign q_we    = accept && pos_ok && (opcode == icnc_pkg::OP_QUERY);
  assign trigger = q_we && (icnc_pkg::LEN_W'(position) == last_pos);

  // ---------------------------------------------------------------
  // Walk sequencer: steps (centroid, element) once per cycle
  // ---------------------------------------------------------------
  logic                       walking;
  logic [icnc_pkg::CEN_W-1:0] cen_cnt;
  logic [icnc_pkg::POS_W-1:0] pos_cnt;
  logic                       step_last, step_final;

  assign step_last  = (icnc_pkg::LEN_W'(pos_cnt) == last_pos);
  assign step_final = (32'(cen_cnt) == icnc_pkg::CENTROIDS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      cen_cnt <= '0;
      pos_cnt <= '0;
    end else if (trigger) begin
      walking <= 1'b1;
      cen_cnt <= '0;
      pos_cnt <= '0;
    end else if (walking) begin
      if (step_last) begin
        pos_cnt <= '0;
        cen_cnt <= cen_cnt + icnc_pkg::CEN_W'(1);
        if (step_final) walking <= 1'b0;
      end else begin
        pos_cnt <= pos_cnt + icnc_pkg::POS_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Stores: codebook (centroid-major rows) and query, registered reads
  // ---------------------------------------------------------------
  logic signed [icnc_pkg::CODE_W-1:0] cb_mem [icnc_pkg::CB_DEPTH];
  logic signed [icnc_pkg::Q_W-1:0]    q_mem  [icnc_pkg::MAX_SUBDIM];
  logic signed [icnc_pkg::CODE_W-1:0] code_rd;
  logic signed [icnc_pkg::Q_W-1:0]    q_rd;

  always_ff @(posedge clk) begin
    if (cb_we)
      cb_mem[{centroid[icnc_pkg::CEN_W-1:0], position[icnc_pkg::POS_W-1:0]}] <= code_value;
    code_rd <= cb_mem[{cen_cnt, pos_cnt}];
  end

  always_ff @(posedge clk) begin
    if (q_we)
      q_mem[position[icnc_pkg::POS_W-1:0]] <= query_value;
    q_rd <= q_mem[pos_cnt];
  end

  // ---------------------------------------------------------------
  // Datapath: read -> scale -> diff/abs -> square -> accumulate -> compare
  // ---------------------------------------------------------------
  icnc_pkg::elem_tag_t tag0, tag1, tag2, tag3, tag4, tag5;
  logic                v1, v2, v3, v4, v5;

  assign tag0.first   = (pos_cnt == '0);
  assign tag0.last    = step_last;
  assign tag0.final_c = step_final;
  assign tag0.cen     = cen_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= walking;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tag0;
    tag2 <= tag1;
    tag3 <= tag2;
    tag4 <= tag3;
    tag5 <= tag4;
  end

  // stage 2: code * scale
  logic signed [icnc_pkg::PROD_W-1:0] code_x, scale_x, prod;
  logic signed [icnc_pkg::Q_W-1:0]    q2;
  assign code_x  = icnc_pkg::PROD_W'(code_rd);
  assign scale_x = icnc_pkg::PROD_W'(scale);

  always_ff @(posedge clk) begin
    prod <= code_x * scale_x;
    q2   <= q_rd;
  end

  // stage 3: |query - (prod + offset)|
  logic signed [icnc_pkg::REC_W-1:0]  rec;
  logic signed [icnc_pkg::DIFF_W-1:0] diff;
  logic [icnc_pkg::MAG_W-1:0]         mag;

  assign rec  = icnc_pkg::REC_W'(prod) + icnc_pkg::REC_W'(offset);
  assign diff = icnc_pkg::DIFF_W'(q2) - icnc_pkg::DIFF_W'(rec);

  always_ff @(posedge clk) begin
    if (diff[icnc_pkg::DIFF_W-1])
      mag <= icnc_pkg::MAG_W'(-diff);
    else
      mag <= icnc_pkg::MAG_W'(diff);
  end

  // stage 4: square
  logic [icnc_pkg::SQ_W-1:0] sq;
  always_ff @(posedge clk) begin
    sq <= mag * mag;
  end

  // stage 5: per-centroid running sum, restarted on element 0
  logic [icnc_pkg::SUM_W-1:0] running_sum;
  always_ff @(posedge clk) begin
    if (rst)
      running_sum <= '0;
    else if (v4)
      running_sum <= (tag4.first ? '0 : running_sum) + icnc_pkg::SUM_W'(sq);
  end

  // stage 6: keep the best; strict less-than so ties keep the lower index
  logic [icnc_pkg::SUM_W-1:0] best_sum;
  logic [icnc_pkg::CEN_W-1:0] best_index;
  logic                       take;

  assign take = (tag5.cen == '0) || (running_sum < best_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_sum   <= '0;
      best_index <= '0;
      done       <= 1'b0;
      nearest    <= '0;
    end else begin
      done <= 1'b0;
      if (v5 && tag5.last) begin
        if (take) begin
          best_sum   <= running_sum;
          best_index <= tag5.cen;
        end
        if (tag5.final_c) begin
          done    <= 1'b1;
          nearest <= 8'(take ? tag5.cen : best_index);
        end
      end
    end
  end

  // busy from the triggering request until the result strobe
  always_ff @(posedge clk) begin
    if (rst)
      busy <= 1'b0;
    else if (trigger)
      busy <= 1'b1;
    else if (v5 && tag5.last && tag5.final_c)
      busy <= 1'b0;
  end

endmodule

// ===== sim/tb_int8_codebook_nearest_centroid.sv =====
// Self-checking bench for the int8 codebook nearest-centroid search block.
module tb_int8_codebook_nearest_centroid;
  timeunit 1ns;
  timeprecision 1ps;

  // generous ceiling: many times the slowest legal run of this stimulus
  localparam int CYCLE_LIMIT = 12_000_000;
  // config index with no register behind it, written to show it is ignored
  localparam logic [icnc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // codebook and query positions filled up front; every search stays within
  localparam int FILL_LEN = 4;
  // subdim per random phase; 0 clamps to 1
  localparam int PHASE_DIMS [0:7] = '{1, 2, 3, 0, 4, 3, 2, 1};

  typedef struct {
    logic                               opcode;
    logic [icnc_pkg::CEN_W-1:0]         centroid;
    logic [icnc_pkg::POS_W-1:0]         position;
    logic signed [icnc_pkg::CODE_W-1:0] code_value;
    logic signed [icnc_pkg::Q_W-1:0]    query_value;
  } request_t;

  // Predicts the nearest index for each final query element and holds the
  // answers still owed by the block, oldest first.
  class nearest_centroid_checker;
    bit signed [icnc_pkg::CODE_W-1:0]  codebook [icnc_pkg::CB_DEPTH];
    bit signed [icnc_pkg::Q_W-1:0]     query_elems [icnc_pkg::MAX_SUBDIM];
    bit signed [icnc_pkg::SCALE_W-1:0] gain;
    bit signed [icnc_pkg::Q_W-1:0]     bias;
    bit [6:0]                          subdim;
    logic [icnc_pkg::CEN_W-1:0]        nearest_due [$];
    int                                mismatches;

    function new();
      gain = icnc_pkg::SCALE_RESET;
      bias = icnc_pkg::OFFSET_RESET;
      subdim = icnc_pkg::SUBDIM_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [icnc_pkg::CFG_IDX_W-1:0] idx,
                            logic [icnc_pkg::CFG_W-1:0] data);
      case (idx)
        icnc_pkg::REG_SCALE:  gain = data[icnc_pkg::SCALE_W-1:0];
        icnc_pkg::REG_OFFSET: bias = data[icnc_pkg::Q_W-1:0];
        icnc_pkg::REG_SUBDIM: subdim = data[6:0];
        default: ;
      endcase
    endfunction

    // elements in use; out-of-range register values clamp
    function int vec_len();
      if (subdim == 0) return 1;
      if (subdim > icnc_pkg::MAX_SUBDIM) return icnc_pkg::MAX_SUBDIM;
      return int'(subdim);
    endfunction

    function longint dequant(int c, int j);
      return longint'(codebook[c*icnc_pkg::MAX_SUBDIM + j]) * longint'(gain)
             + longint'(bias);
    endfunction

    function logic [icnc_pkg::CEN_W-1:0] find_nearest();
      longint unsigned sq_sum, best_sq;
      longint          delta, mag;
      int              len, best;
      len = vec_len();
      best = 0;
      best_sq = 0;
      for (int c = 0; c < icnc_pkg::CENTROIDS; c++) begin
        sq_sum = 0;
        for (int j = 0; j < len; j++) begin
          delta = longint'(query_elems[j]) - dequant(c, j);
          mag = (delta < 0) ? -delta : delta;
          sq_sum += mag * mag;
        end
        // strict compare keeps the lowest index on a tie
        if (c == 0 || sq_sum < best_sq) begin
          best_sq = sq_sum;
          best = c;
        end
      end
      return icnc_pkg::CEN_W'(best);
    endfunction

    function void note_request(request_t r);
      if (r.opcode == icnc_pkg::OP_CODE) begin
        codebook[int'(r.centroid)*icnc_pkg::MAX_SUBDIM + int'(r.position)] = r.code_value;
      end else begin
        query_elems[r.position] = r.query_value;
        if (int'(r.position) == vec_len() - 1) nearest_due.push_back(find_nearest());
      end
    endfunction

    function void check_nearest(logic [icnc_pkg::CEN_W-1:0] got);
      logic [icnc_pkg::CEN_W-1:0] want;
      if (nearest_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: nearest %0d", got);
        mismatches++;
      end else begin
        want = nearest_due.pop_front();
        if (got !== want) begin
          if (mismatches < 10) $display("nearest mismatch: expected %0d got %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic                               opcode;
  logic [7:0]                         centroid;
  logic [5:0]                         position;
  logic signed [7:0]                  code_value;
  logic signed [23:0]                 query_value;
  logic                               cfg_we;
  logic [icnc_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [icnc_pkg::CFG_W-1:0]         cfg_data;
  logic [7:0]                         nearest;
  logic                               done;

  nearest_centroid_checker sb;
  int burst_left = 0;
  int cycles = 0;

  int8_codebook_nearest_centroid DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .centroid(centroid),
    .position(position),
    .code_value(code_value),
    .query_value(query_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .nearest(nearest),
    .done(done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // done is a one-cycle strobe; every pulse carries one answer
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) sb.check_nearest(nearest);
  end

  // One request. Sender works in bursts: before each burst, a random gap with
  // start low. Inside a burst, start stays high from request to request.
  task automatic send_request(input logic op, input logic [7:0] cen, input logic [5:0] pos,
                              input logic signed [7:0] code, input logic signed [23:0] qv);
    request_t r;
    r.opcode = op;
    r.centroid = cen;
    r.position = pos;
    r.code_value = code;
    r.query_value = qv;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(16, 80))
                                               : int'($urandom_range(1, 12));
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    opcode <= r.opcode;
    centroid <= r.centroid;
    position <= r.position;
    code_value <= r.code_value;
    query_value <= r.query_value;
    // accepted at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  // hold off until every owed answer is in and the block has settled
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.nearest_due.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [icnc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [icnc_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // all three registers, only with the block idle; unused data bits random
  task automatic write_settings(input logic [15:0] s, input logic [23:0] o, input logic [6:0] d);
    logic [icnc_pkg::CFG_W-1:0] word;
    wait_idle();
    word = 24'($urandom);
    word[15:0] = s;
    put_reg(icnc_pkg::REG_SCALE, word);
    put_reg(icnc_pkg::REG_OFFSET, o);
    word = 24'($urandom);
    word[6:0] = d;
    put_reg(icnc_pkg::REG_SUBDIM, word);
    if ($urandom_range(0, 1) == 1) put_reg(REG_SPARE, 24'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly whole query vectors (often close to one centroid
  // so the winner is well defined), plus codebook rewrites and stray elements.
  task automatic run_phase(input int n);
    int     left, len, tgt, roll;
    bit     near;
    longint v;
    left = n;
    len = sb.vec_len();
    while (left > 0) begin
      roll = int'($urandom_range(0, 99));
      if (roll < 35) begin
        send_request(icnc_pkg::OP_CODE, 8'($urandom), 6'($urandom), 8'($urandom),
                     24'($urandom));
        left--;
      end else if (roll < 85) begin
        tgt = int'($urandom_range(0, icnc_pkg::CENTROIDS - 1));
        near = ($urandom_range(0, 2) != 0);
        for (int j = 0; j < len; j++) begin
          if (near) begin
            v = sb.dequant(tgt, j) + longint'($urandom_range(0, 2047)) - 64'sd1024;
            if (v > 64'sd8388607) v = 64'sd8388607;
            if (v < -64'sd8388608) v = -64'sd8388608;
          end else begin
            v = longint'($signed(24'($urandom)));
          end
          send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'(j), 8'($urandom), 24'(v));
        end
        left -= len;
      end else begin
        send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'($urandom), 8'($urandom),
                     24'($urandom));
        left--;
      end
      // now and then drain completely mid-phase
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
  endtask

  initial begin
    logic [15:0] s;
    logic [23:0] o;
    logic [6:0]  d;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    opcode <= icnc_pkg::OP_CODE;
    centroid <= '0;
    position <= '0;
    code_value <= '0;
    query_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= icnc_pkg::REG_SCALE;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the first FILL_LEN positions of every centroid and of the query
    // first; no search ever runs longer, so nothing is read before written.
    // Default subdim 8 keeps these query slots from firing a search.
    for (int c = 0; c < icnc_pkg::CENTROIDS; c++)
      for (int j = 0; j < FILL_LEN; j++)
        send_request(icnc_pkg::OP_CODE, 8'(c), 6'(j), 8'($urandom), 24'($urandom));
    for (int j = 0; j < FILL_LEN; j++)
      send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'(j), 8'($urandom), 24'($urandom));

    // zero gain: every centroid sits on the offset, all tie, lowest wins
    write_settings(16'h0000, 24'h5A5A5A, 7'd1);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd0, 8'($urandom), 24'h000000);

    // max gain, min offset, extreme codes and queries
    write_settings(16'h7FFF, 24'h800000, 7'd2);
    send_request(icnc_pkg::OP_CODE, 8'd200, 6'd0, 8'sh7F, 24'($urandom));
    send_request(icnc_pkg::OP_CODE, 8'd200, 6'd1, 8'sh7F, 24'($urandom));
    send_request(icnc_pkg::OP_CODE, 8'd255, 6'd0, 8'sh80, 24'($urandom));
    send_request(icnc_pkg::OP_CODE, 8'd255, 6'd1, 8'sh80, 24'($urandom));
    // past the end: stored only
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd5, 8'($urandom), 24'h123456);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd0, 8'($urandom), 24'h7FFFFF);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd1, 8'($urandom), 24'h7FFFFF);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd0, 8'($urandom), 24'h800000);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd1, 8'($urandom), 24'h800000);

    // min gain, max offset, subdim 0 clamps to one element
    write_settings(16'h8000, 24'h7FFFFF, 7'd0);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd63, 8'($urandom), 24'($urandom));
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd0, 8'($urandom), 24'h800000);

    // subdim above the store clamps to full length: these are not the last
    write_settings(icnc_pkg::SCALE_RESET, icnc_pkg::OFFSET_RESET, 7'd127);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd0, 8'($urandom), 24'($urandom));
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd62, 8'($urandom), 24'h7FFFFF);

    // full length written exactly: position 62 is not the last
    write_settings(icnc_pkg::SCALE_RESET, icnc_pkg::OFFSET_RESET, 7'd64);
    send_request(icnc_pkg::OP_QUERY, 8'($urandom), 6'd62, 8'($urandom), 24'($urandom));

    // random phases; short vectors keep the walks cheap
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 3))
        0: s = 16'h7FFF;
        1: s = 16'h8000;
        default: s = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: o = 24'h7FFFFF;
        1: o = 24'h800000;
        2: o = 24'($urandom_range(0, 65535) - 32768);
        default: o = 24'($urandom);
      endcase
      d = 7'(PHASE_DIMS[p]);
      write_settings(s, o, d);
      run_phase(40);
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (sb.mismatches == 0 && sb.nearest_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== int8_codebook_nearest_centroid.f =====
rtl/core/icnc_pkg.sv
rtl/core/int8_codebook_nearest_centroid.sv
sim/tb_int8_codebook_nearest_centroid.sv
